@@ rtl/core/mep_pkg.sv @@
package mep_pkg;

    // Fixed-point format of every real value: two's complement, 64 bits.
    localparam int FRAC_BITS = 59;
    // Pixel indices at or beyond this value are clamped to it minus one.
    localparam int COORD_MAX = 4096;
    // Width of the usable part of the iteration limit.
    localparam int ITER_BITS = 16;

    localparam logic [15:0] ITER_MASK = 16'((64'd1 << ITER_BITS) - 64'd1);

    localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

    // Clamped index and signed offset from the image middle.
    localparam int IDX_W  = 17;
    localparam int DIFF_W = 18;

    // Color offset added to the scaled escape count.
    localparam logic [7:0] COLOR_BIAS = 8'd5;

    // Configuration register indices.
    localparam logic [2:0] REG_CENTER_X  = 3'd0;
    localparam logic [2:0] REG_CENTER_Y  = 3'd1;
    localparam logic [2:0] REG_STEP      = 3'd2;
    localparam logic [2:0] REG_LIMIT     = 3'd3;
    localparam logic [2:0] REG_MAX_ITER  = 3'd4;
    localparam logic [2:0] REG_WIDTH     = 3'd5;
    localparam logic [2:0] REG_HEIGHT    = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [63:0] CENTER_X_RST = 64'(-64'sd428681081047376314);
    localparam logic [63:0] CENTER_Y_RST = 64'd75992493804103270;
    localparam logic [62:0] STEP_RST     = 63'd10540584856;
    localparam logic [62:0] LIMIT_RST    = 63'd2305843009213693952;
    localparam logic [15:0] MAX_ITER_RST = 16'd1000;
    localparam logic [12:0] WIDTH_RST    = 13'd800;
    localparam logic [12:0] HEIGHT_RST   = 13'd600;

    // Multiplier operations; the operation also names the destination register.
    localparam logic [2:0] MOP_NONE = 3'd0;
    localparam logic [2:0] MOP_CX   = 3'd1;
    localparam logic [2:0] MOP_CY   = 3'd2;
    localparam logic [2:0] MOP_XY   = 3'd3;
    localparam logic [2:0] MOP_XX   = 3'd4;
    localparam logic [2:0] MOP_YY   = 3'd5;

    // Product scaling.
    localparam logic [1:0] SH_ZERO  = 2'd0;
    localparam logic [1:0] SH_FRAC  = 2'd1;
    localparam logic [1:0] SH_FRAC1 = 2'd2;

    // Datapath operations.
    localparam logic [2:0] AOP_NONE    = 3'd0;
    localparam logic [2:0] AOP_INIT    = 3'd1;
    localparam logic [2:0] AOP_DIFF    = 3'd2;
    localparam logic [2:0] AOP_XNEW    = 3'd3;
    localparam logic [2:0] AOP_MAG     = 3'd4;
    localparam logic [2:0] AOP_DIVINIT = 3'd5;
    localparam logic [2:0] AOP_DIVSTEP = 3'd6;

    // Jump conditions.
    localparam logic [1:0] J_NEXT    = 2'd0;
    localparam logic [1:0] J_IF_END  = 2'd1;
    localparam logic [1:0] J_IF_CONT = 2'd2;

    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] PC_LOOP = PC_W'(8);
    localparam logic [PC_W-1:0] PC_FIN  = PC_W'(24);

    typedef struct packed {
        logic [2:0]      mop;
        logic [2:0]      aop;
        logic [1:0]      jcond;
        logic [PC_W-1:0] target;
        logic            fin;
    } ctrl_t;

    typedef struct packed {
        logic at_end;
        logic cont;
    } seq_flags_t;

    typedef struct packed {
        logic        vld;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] off;
        logic [1:0]  shsel;
        logic [2:0]  dst;
    } mul_req_t;

    typedef struct packed {
        logic        vld;
        logic [2:0]  dst;
        logic [63:0] val;
    } mul_rsp_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            sat_add = a[63] ? Q_MIN : Q_MAX;
        end
        else begin
            sat_add = s;
        end
    endfunction

    // Signed offset of a pixel index from half the image size.
    function automatic logic [DIFF_W-1:0] coord_diff(input logic [11:0] idx,
                                                     input logic [12:0] size);
        logic [IDX_W-1:0] cl;
        cl = IDX_W'(idx);
        if (cl >= IDX_W'(COORD_MAX)) begin
            cl = IDX_W'(COORD_MAX - 1);
        end
        coord_diff = {1'b0, cl} - DIFF_W'(size[12:1]);
    endfunction

    // Microprogram. One iteration of z = z^2 + c runs from PC_LOOP to the
    // conditional jump back; the empty steps cover the latency of the multiplier,
    // whose result is readable only after its register stages and write-back.
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '0;
        case (pc) inside
            PC_W'(0):
            begin
                w.mop = MOP_CX;
                w.aop = AOP_INIT;
            end
            PC_W'(1):  w.mop = MOP_CY;
            PC_W'(7):
            begin
                w.jcond  = J_IF_END;
                w.target = PC_FIN;
            end
            PC_LOOP:   w.mop = MOP_XY;
            PC_W'(14): w.aop = AOP_DIFF;
            PC_W'(15):
            begin
                w.aop = AOP_XNEW;
                w.mop = MOP_YY;
            end
            PC_W'(16): w.mop = MOP_XX;
            PC_W'(22): w.aop = AOP_MAG;
            PC_W'(23):
            begin
                w.jcond  = J_IF_CONT;
                w.target = PC_LOOP;
            end
            PC_FIN:    w.aop = AOP_DIVINIT;
            [PC_FIN + PC_W'(1) : PC_FIN + PC_W'(8)]: w.aop = AOP_DIVSTEP;
            PC_FIN + PC_W'(9): w.fin = 1'b1;
            default:   w = '0;
        endcase
        ucode = w;
    endfunction

endpackage

@@ rtl/core/mandelbrot_escape_pixel.sv @@
// Channel   Dir  Signals                                       Transfer at rising edge
// -------   ---  --------------------------------------------  -----------------------------
// config    in   wr_en, wr_index, wr_data                      wr_en high
// pixel     in   start, column, row; busy out                  start high and busy low
// result    out  done, red, green, blue, iterations, escaped   done high (one cycle only)
//
// A pixel's time from its accepting edge to the edge that raises done grows
// with the number of updates of z, which the reset limit caps at 1000. Each
// update is one pass through the loop of the microprogram, whose length is set
// by the latency of the shared multiplier, which is issued three times per
// update with two dependent waits.
// Reset is asynchronous and active low; the configuration registers return to
// their default view of the plane. The receiver cannot stall: done lasts
// exactly one cycle, and busy is already low in that cycle so that the next
// pixel may be transferred at the same edge that takes the result.
module mandelbrot_escape_pixel
    import mep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [63:0] wr_data,
    input  logic        start,
    input  logic [11:0] column,
    input  logic [11:0] row,
    output logic        busy,
    output logic        done,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [15:0] iterations,
    output logic        escaped
);

    // Configuration registers.
    logic [63:0] center_x_reg, center_y_reg;
    logic [62:0] step_reg, limit_reg;
    logic [15:0] max_reg;
    logic [12:0] width_reg, height_reg;

    // Datapath registers. The point c, the orbit point z, its squares,
    // the doubled cross product t and the difference of squares d.
    logic [DIFF_W-1:0] dx_reg, dy_reg;
    logic [63:0] cx_reg, cy_reg, x_reg, y_reg, x2_reg, y2_reg, t_reg, d_reg;
    logic [63:0] cx_next, cy_next, x_next, y_next, x2_next, y2_next, t_next, d_next;
    logic [15:0] iter_reg, iter_next;
    logic        esc_reg, esc_next;

    // Color divider: remainder, dividend bits still to shift in, quotient.
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  low_reg, low_next;
    logic [7:0]  quo_reg, quo_next;
    logic [23:0] num_w;
    logic [16:0] r17_w;

    logic        done_reg;
    logic [7:0]  color_reg;
    logic [15:0] iter_out_reg;
    logic        escaped_reg;
    logic        ok_w;

    ctrl_t       ctrl;
    seq_flags_t  flags;
    mul_req_t    req;
    mul_rsp_t    rsp;

    mep_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    mep_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Configuration writes; the user must make them only while idle: nothing enforces it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
            step_reg     <= STEP_RST;
            limit_reg    <= LIMIT_RST;
            max_reg      <= MAX_ITER_RST;
            width_reg    <= WIDTH_RST;
            height_reg   <= HEIGHT_RST;
        end
        else if (wr_en) begin
            case (wr_index)
                REG_CENTER_X: center_x_reg <= wr_data;
                REG_CENTER_Y: center_y_reg <= wr_data;
                REG_STEP:     step_reg     <= wr_data[62:0];
                REG_LIMIT:    limit_reg    <= wr_data[62:0];
                REG_MAX_ITER: max_reg      <= wr_data[15:0] & ITER_MASK;
                REG_WIDTH:    width_reg    <= wr_data[12:0];
                REG_HEIGHT:   height_reg   <= wr_data[12:0];
                default:      ;
            endcase
        end
    end

    // The pixel offsets are latched when the pixel is transferred in.
    always_ff @(posedge clk)
    begin
        if (start && !busy) begin
            dx_reg <= coord_diff(column, width_reg);
            dy_reg <= coord_diff(row, height_reg);
        end
    end

    // Operand selection for the multiplier. Mapping a pixel to c is one
    // product plus the center with no scaling; the orbit products are
    // scaled back to the fixed-point format, the cross product one bit less.
    always_comb
    begin
        req.vld   = (ctrl.mop != MOP_NONE);
        req.dst   = ctrl.mop;
        req.a     = x_reg;
        req.b     = x_reg;
        req.off   = '0;
        req.shsel = SH_FRAC;
        case (ctrl.mop)
            MOP_CX:
            begin
                req.a     = {{(64 - DIFF_W){dx_reg[DIFF_W-1]}}, dx_reg};
                req.b     = {1'b0, step_reg};
                req.off   = center_x_reg;
                req.shsel = SH_ZERO;
            end
            MOP_CY:
            begin
                req.a     = {{(64 - DIFF_W){dy_reg[DIFF_W-1]}}, dy_reg};
                req.b     = {1'b0, step_reg};
                req.off   = center_y_reg;
                req.shsel = SH_ZERO;
            end
            MOP_XY:
            begin
                req.b     = y_reg;
                req.shsel = SH_FRAC1;
            end
            MOP_YY:
            begin
                req.a     = y_reg;
                req.b     = y_reg;
            end
            default: ;
        endcase
    end

    // Datapath updates: multiplier write-back first, then the operation of
    // the current microinstruction.
    always_comb
    begin
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        x2_next   = x2_reg;
        y2_next   = y2_reg;
        t_next    = t_reg;
        d_next    = d_reg;
        iter_next = iter_reg;
        esc_next  = esc_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        num_w     = {iter_reg, 8'd0} - {8'd0, iter_reg};
        r17_w     = {rem_reg, low_reg[7]};

        if (rsp.vld) begin
            case (rsp.dst)
                MOP_CX:  cx_next = rsp.val;
                MOP_CY:  cy_next = rsp.val;
                MOP_XY:  t_next  = rsp.val;
                MOP_XX:  x2_next = rsp.val;
                MOP_YY:  y2_next = rsp.val;
                default: ;
            endcase
        end

        case (ctrl.aop)
            AOP_INIT:
            begin
                x_next    = '0;
                y_next    = '0;
                x2_next   = '0;
                y2_next   = '0;
                iter_next = '0;
                esc_next  = 1'b0;
            end
            AOP_DIFF:
            begin
                d_next    = sat_add(x2_reg, 64'd0 - y2_reg);
                y_next    = sat_add(t_reg, cy_reg);
                iter_next = iter_reg + 16'd1;
            end
            AOP_XNEW:
            begin
                x_next = sat_add(d_reg, cx_reg);
            end
            AOP_MAG:
            begin
                // A saturated negative sum reads as a huge unsigned value.
                esc_next = (sat_add(x2_reg, y2_reg) >= {1'b0, limit_reg});
            end
            AOP_DIVINIT:
            begin
                // 255 * i is formed as 256 * i - i. Its upper part is below
                // the limit whenever the color is used, so eight restoring
                // steps yield the whole quotient.
                rem_next = num_w[23:8];
                low_next = num_w[7:0];
                quo_next = '0;
            end
            AOP_DIVSTEP:
            begin
                if (r17_w >= {1'b0, max_reg}) begin
                    rem_next = 16'(r17_w - {1'b0, max_reg});
                    quo_next = {quo_reg[6:0], 1'b1};
                end
                else begin
                    rem_next = r17_w[15:0];
                    quo_next = {quo_reg[6:0], 1'b0};
                end
                low_next = {low_reg[6:0], 1'b0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        x2_reg   <= x2_next;
        y2_reg   <= y2_next;
        t_reg    <= t_next;
        d_reg    <= d_next;
        iter_reg <= iter_next;
        esc_reg  <= esc_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quo_reg  <= quo_next;
    end

    // Loop conditions for the sequencer.
    always_comb
    begin
        flags.at_end = (iter_reg >= max_reg);
        flags.cont   = !esc_reg && (iter_reg < max_reg);
    end

    // An escape on the last allowed update still counts as black.
    assign ok_w = esc_reg && (iter_reg < max_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= ctrl.fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fin) begin
            color_reg    <= ok_w ? quo_reg + COLOR_BIAS : 8'd0;
            iter_out_reg <= iter_reg;
            escaped_reg  <= ok_w;
        end
    end

    assign done       = done_reg;
    assign red        = 8'd0;
    assign green      = color_reg;
    assign blue       = color_reg;
    assign iterations = iter_out_reg;
    assign escaped    = escaped_reg;

endmodule

@@ rtl/core/mep_mul.sv @@
module mep_mul
    import mep_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    // Five register stages: magnitudes, partial products, partial sums,
    // full product, signed product plus offset. Scaling and saturation
    // follow the last stage combinationally.
    logic [4:0]   vld_reg;
    logic [2:0]   dst_reg   [5];
    logic [1:0]   sh_reg    [5];
    logic         neg_reg   [5];
    logic [63:0]  off_reg   [4];

    logic [63:0]  ma_reg, mb_reg;
    logic [63:0]  pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [127:0] cat_reg;
    logic [64:0]  mid_reg;
    logic [127:0] sum_reg;
    logic [127:0] sv_reg;

    logic [63:0]  ma_next, mb_next;
    logic [127:0] w_scaled;
    logic         fits;

    always_comb
    begin
        ma_next = req.a[63] ? 64'd0 - req.a : req.a;
        mb_next = req.b[63] ? 64'd0 - req.b : req.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            vld_reg <= {vld_reg[3:0], req.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg[0] <= req.dst;
        sh_reg[0]  <= req.shsel;
        neg_reg[0] <= req.a[63] ^ req.b[63];
        off_reg[0] <= req.off;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        for (int k = 1; k < 5; k++) begin
            dst_reg[k] <= dst_reg[k-1];
            sh_reg[k]  <= sh_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
        end
        for (int k = 1; k < 4; k++) begin
            off_reg[k] <= off_reg[k-1];
        end

        pp00_reg <= {32'd0, ma_reg[31:0]}  * {32'd0, mb_reg[31:0]};
        pp01_reg <= {32'd0, ma_reg[31:0]}  * {32'd0, mb_reg[63:32]};
        pp10_reg <= {32'd0, ma_reg[63:32]} * {32'd0, mb_reg[31:0]};
        pp11_reg <= {32'd0, ma_reg[63:32]} * {32'd0, mb_reg[63:32]};

        cat_reg <= {pp11_reg, pp00_reg};
        mid_reg <= {1'b0, pp01_reg} + {1'b0, pp10_reg};

        sum_reg <= cat_reg + {31'd0, mid_reg, 32'd0};

        sv_reg <= {{64{off_reg[3][63]}}, off_reg[3]}
                  + (sum_reg ^ {128{neg_reg[3]}})
                  + {127'd0, neg_reg[3]};
    end

    always_comb
    begin
        case (sh_reg[4])
            SH_FRAC:  w_scaled = 128'($signed(sv_reg) >>> FRAC_BITS);
            SH_FRAC1: w_scaled = 128'($signed(sv_reg) >>> (FRAC_BITS - 1));
            default:  w_scaled = sv_reg;
        endcase
        fits = (w_scaled[127:63] == {65{1'b0}}) || (w_scaled[127:63] == {65{1'b1}});
        rsp.vld = vld_reg[4];
        rsp.dst = dst_reg[4];
        rsp.val = fits ? w_scaled[63:0] : (w_scaled[127] ? Q_MIN : Q_MAX);
    end

endmodule

@@ rtl/core/mep_seq.sv @@
module mep_seq
    import mep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  seq_flags_t flags,
    output ctrl_t      ctrl,
    output logic       busy
);

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            busy_reg, busy_next;
    logic            taken;

    always_comb
    begin
        ctrl = busy_reg ? ucode(pc_reg) : '0;
        case (ctrl.jcond)
            J_IF_END:  taken = flags.at_end;
            J_IF_CONT: taken = flags.cont;
            default:   taken = 1'b0;
        endcase

        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start && !busy_reg) begin
            pc_next   = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg) begin
            if (ctrl.fin) begin
                busy_next = 1'b0;
            end
            else if (taken) begin
                pc_next = ctrl.target;
            end
            else begin
                pc_next = pc_reg + PC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg   <= '0;
            busy_reg <= 1'b0;
        end
        else begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

@@ rtl/core/mep_chk.sv @@
module mep_chk
    import mep_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       busy,
    input logic       done,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic       escaped
);

    // The block finishes a pixel only by delivering its result.
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result transfer");

    // Results never come back to back.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // Red stays dark and blue mirrors green.
    a_color_shape: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (red == 8'd0 && green == blue))
        else $error("color channels inconsistent");

    // A pixel that did not escape in time is black.
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !escaped) |-> (green == 8'd0))
        else $error("non-escaped pixel is not black");

endmodule

bind mandelbrot_escape_pixel mep_chk u_mep_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .busy    (busy),
    .done    (done),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .escaped (escaped)
);
